### hw/rtl/soa_pkg.sv
// Shared types and constants for the slab object allocator.
// Used by every module of the block; no dependencies.
`default_nettype none
package soa_pkg;

    localparam int NUM_PAGES   = 64;
    localparam int PAGE_W      = 6;
    localparam int NUM_CLASSES = 9;
    localparam int OBJ_W       = 9;
    localparam int LINK_W      = 10;
    localparam int OFF_W       = 12;
    localparam int ADDR_W      = 18;

    localparam logic [6:0]  NIL_PAGE      = 7'd64;
    localparam logic [3:0]  MAX_CLASS     = 4'd8;
    localparam logic [15:0] MAX_OBJ_BYTES = 16'd2048;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] K_ALLOC  = 2'd0;
    localparam logic [1:0] K_FREE   = 2'd1;
    localparam logic [1:0] K_REJECT = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_NO_PAGE   = 2'd2;
    localparam logic [1:0] ST_UNOWNED   = 2'd3;

    typedef struct packed {
        logic        opcode;
        logic [15:0] request_size;
        logic [15:0] request_align;
        logic [17:0] free_address;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] object_address;
        logic [3:0]  size_class;
        logic        page_released;
    } result_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [3:0]        cls;
        logic [PAGE_W-1:0] page;
        logic [OFF_W-1:0]  offset;
    } work_t;

    typedef struct packed {
        logic [3:0]        owner;
        logic [LINK_W-1:0] count;
        logic [LINK_W-1:0] head;
        logic [6:0]        next;
        logic [6:0]        prev;
    } page_meta_t;

endpackage
`default_nettype wire

### hw/rtl/slab_object_allocator.sv
// Top level of the slab object allocator: classifier, request queue, engine.
// Depends on soa_pkg, soa_front, soa_queue, soa_back.
//
// Slab allocator over 64 pages of 4096 bytes with nine classes of 8 to 2048
// bytes; one result per request, in request order. Requests are classified
// and queued up front while the engine works, so s_ready stays high until the
// queue fills. Timing is set by the single-port page metadata and object link
// memories; an allocate that opens a fresh page writes every link of that
// page. A result waits in the output register without holding the engine
// beyond one request.
`default_nettype none
module slab_object_allocator
    import soa_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  request_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output result_t  m_data
);

    work_t front_work, q_data;
    logic  q_valid, q_pop;

    soa_front u_front (
        .req  (s_data),
        .work (front_work)
    );

    soa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_data  (front_work),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    soa_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

### hw/rtl/soa_front.sv
// Request classifier: size class selection, oversize screening, free address split.
// Depends on soa_pkg.
`default_nettype none
module soa_front
    import soa_pkg::*;
(
    input  request_t req,
    output work_t    work
);

    logic [15:0] size;
    logic [3:0]  cls;

    always_comb begin
        size = (req.request_align > req.request_size) ? req.request_align : req.request_size;
        cls = MAX_CLASS;
        for (int i = NUM_CLASSES - 2; i >= 0; i--) begin
            if (size <= (16'd8 << i)) begin
                cls = 4'(i);
            end
        end
        work.page   = req.free_address[ADDR_W-1:OFF_W];
        work.offset = req.free_address[OFF_W-1:0];
        work.cls    = cls;
        if (req.opcode == OP_FREE) begin
            work.kind = K_FREE;
        end else if (size > MAX_OBJ_BYTES) begin
            work.kind = K_REJECT;
        end else begin
            work.kind = K_ALLOC;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/soa_queue.sv
// Short FIFO of classified requests between front and back.
// Depends on soa_pkg.
`default_nettype none
module soa_queue
    import soa_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  work_t push_data,
    output logic  pop_valid,
    input  logic  pop,
    output work_t pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    work_t         slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### hw/rtl/soa_back.sv
// Allocator engine: page metadata and object link memories, class lists, sequencer.
// Depends on soa_pkg.
`default_nettype none
module soa_back
    import soa_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    output logic    q_pop,
    input  work_t   q_data,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_A1   = 4'd1;
    localparam logic [3:0] S_A2   = 4'd2;
    localparam logic [3:0] S_CV   = 4'd3;
    localparam logic [3:0] S_F1   = 4'd4;
    localparam logic [3:0] S_PH   = 4'd5;
    localparam logic [3:0] S_PH2  = 4'd6;
    localparam logic [3:0] S_RV   = 4'd7;
    localparam logic [3:0] S_RV2  = 4'd8;
    localparam logic [3:0] S_RN   = 4'd9;
    localparam logic [3:0] S_RN2  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    page_meta_t        pm_mem [NUM_PAGES];
    page_meta_t        pm_q, pm_wdata;
    logic              pm_we, pm_re;
    logic [PAGE_W-1:0] pm_waddr, pm_raddr;

    logic [LINK_W-1:0]       ol_mem [NUM_PAGES << OBJ_W];
    logic [LINK_W-1:0]       ol_q, ol_wdata;
    logic                    ol_we, ol_re;
    logic [PAGE_W+OBJ_W-1:0] ol_waddr, ol_raddr;

    logic [3:0]           state_reg, state_next;
    logic [NUM_PAGES-1:0] free_map_reg, free_map_next;
    logic [6:0]           head_reg [NUM_CLASSES];
    logic [6:0]           head_next [NUM_CLASSES];
    logic [3:0]           cls_reg, cls_next;
    logic [PAGE_W-1:0]    page_reg, page_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic [OBJ_W-1:0]     k_reg, k_next;
    logic [6:0]           hd_reg, hd_next, nx_reg, nx_next, pv_reg, pv_next;
    result_t              res_reg, res_next;
    result_t              out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic [PAGE_W-1:0] low_free;

    always_comb begin
        low_free = '0;
        for (int i = NUM_PAGES - 1; i >= 0; i--) begin
            if (free_map_reg[i]) begin
                low_free = PAGE_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pm_we) begin
            pm_mem[pm_waddr] <= pm_wdata;
        end
        if (pm_re) begin
            pm_q <= pm_mem[pm_raddr];
        end
        if (ol_we) begin
            ol_mem[ol_waddr] <= ol_wdata;
        end
        if (ol_re) begin
            ol_q <= ol_mem[ol_raddr];
        end
    end

    always_comb begin
        logic [6:0]       h;
        logic [OBJ_W-1:0] msk, k, kk;
        logic [LINK_W-1:0] cnt;
        logic [3:0]       co;

        state_next     = state_reg;
        free_map_next  = free_map_reg;
        head_next      = head_reg;
        cls_next       = cls_reg;
        page_next      = page_reg;
        off_next       = off_reg;
        k_next         = k_reg;
        hd_next        = hd_reg;
        nx_next        = nx_reg;
        pv_next        = pv_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        q_pop    = 1'b0;
        pm_we    = 1'b0;
        pm_re    = 1'b0;
        pm_waddr = page_reg;
        pm_raddr = page_reg;
        pm_wdata = pm_q;
        ol_we    = 1'b0;
        ol_re    = 1'b0;
        ol_waddr = '0;
        ol_raddr = '0;
        ol_wdata = '0;
        h   = head_reg[cls_reg];
        msk = 9'h1FF >> cls_reg;
        k   = '0;
        kk  = '0;
        cnt = '0;
        co  = cls_reg;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    cls_next  = q_data.cls;
                    page_next = q_data.page;
                    off_next  = q_data.offset;
                    res_next  = '0;
                    h = head_reg[q_data.cls];
                    case (q_data.kind)
                        K_REJECT: begin
                            res_next.status = ST_TOO_LARGE;
                            state_next = S_OUT;
                        end
                        K_FREE: begin
                            if (free_map_reg[q_data.page]) begin
                                res_next.status = ST_UNOWNED;
                                state_next = S_OUT;
                            end else begin
                                pm_re = 1'b1;
                                pm_raddr = q_data.page;
                                state_next = S_F1;
                            end
                        end
                        default: begin
                            res_next.size_class = q_data.cls;
                            if (h != NIL_PAGE) begin
                                page_next = h[PAGE_W-1:0];
                                pm_re = 1'b1;
                                pm_raddr = h[PAGE_W-1:0];
                                state_next = S_A1;
                            end else if (free_map_reg == '0) begin
                                res_next.status = ST_NO_PAGE;
                                state_next = S_OUT;
                            end else begin
                                page_next = low_free;
                                k_next = '0;
                                state_next = S_CV;
                            end
                        end
                    endcase
                end
            end
            S_A1: begin
                k = pm_q.head[OBJ_W-1:0] & msk;
                k_next = k;
                ol_re = 1'b1;
                ol_raddr = {page_reg, OBJ_W'(k << cls_reg)};
                state_next = S_A2;
            end
            S_A2: begin
                cnt = pm_q.count - 1'b1;
                pm_we = 1'b1;
                pm_wdata = pm_q;
                pm_wdata.count = cnt;
                pm_wdata.head = ol_q;
                res_next.object_address = {page_reg, OBJ_W'(k_reg << cls_reg), 3'b000};
                if (cnt == '0) begin
                    pm_wdata.next = NIL_PAGE;
                    pm_wdata.prev = NIL_PAGE;
                    nx_next = pm_q.next;
                    pv_next = pm_q.prev;
                    state_next = S_RV;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_CV: begin
                ol_we = 1'b1;
                ol_waddr = {page_reg, OBJ_W'(k_reg << cls_reg)};
                ol_wdata = (k_reg == '0) ? '0 : LINK_W'(k_reg - 1'b1);
                if (k_reg == msk) begin
                    pm_we = 1'b1;
                    pm_wdata.owner = cls_reg;
                    pm_wdata.count = LINK_W'(msk);
                    pm_wdata.head = LINK_W'(msk - 1'b1);
                    pm_wdata.next = h;
                    pm_wdata.prev = NIL_PAGE;
                    free_map_next[page_reg] = 1'b0;
                    res_next.object_address = {page_reg, OBJ_W'(k_reg << cls_reg), 3'b000};
                    hd_next = h;
                    state_next = S_PH;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_F1: begin
                co = (pm_q.owner > MAX_CLASS) ? MAX_CLASS : pm_q.owner;
                msk = 9'h1FF >> co;
                k = OBJ_W'(off_reg >> (co + 4'd3));
                kk = off_reg[OFF_W-1:3] & (9'h1FF << co);
                cnt = pm_q.count + 1'b1;
                h = head_reg[co];
                cls_next = co;
                res_next.size_class = co;
                ol_we = 1'b1;
                ol_waddr = {page_reg, kk};
                ol_wdata = pm_q.head;
                pm_we = 1'b1;
                pm_wdata = pm_q;
                pm_wdata.count = cnt;
                pm_wdata.head = LINK_W'(k);
                if (cnt == LINK_W'(1)) begin
                    pm_wdata.next = h;
                    pm_wdata.prev = NIL_PAGE;
                    hd_next = h;
                    state_next = S_PH;
                end else if (cnt > LINK_W'(msk)) begin
                    nx_next = pm_q.next;
                    pv_next = pm_q.prev;
                    free_map_next[page_reg] = 1'b1;
                    res_next.page_released = 1'b1;
                    state_next = S_RV;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_PH: begin
                head_next[cls_reg] = {1'b0, page_reg};
                if (hd_reg != NIL_PAGE) begin
                    pm_re = 1'b1;
                    pm_raddr = hd_reg[PAGE_W-1:0];
                    state_next = S_PH2;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_PH2: begin
                pm_we = 1'b1;
                pm_waddr = hd_reg[PAGE_W-1:0];
                pm_wdata.prev = {1'b0, page_reg};
                state_next = S_OUT;
            end
            S_RV: begin
                if (pv_reg != NIL_PAGE) begin
                    pm_re = 1'b1;
                    pm_raddr = pv_reg[PAGE_W-1:0];
                    state_next = S_RV2;
                end else begin
                    head_next[cls_reg] = nx_reg;
                    state_next = S_RN;
                end
            end
            S_RV2: begin
                pm_we = 1'b1;
                pm_waddr = pv_reg[PAGE_W-1:0];
                pm_wdata.next = nx_reg;
                state_next = S_RN;
            end
            S_RN: begin
                if (nx_reg != NIL_PAGE) begin
                    pm_re = 1'b1;
                    pm_raddr = nx_reg[PAGE_W-1:0];
                    state_next = S_RN2;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_RN2: begin
                pm_we = 1'b1;
                pm_waddr = nx_reg[PAGE_W-1:0];
                pm_wdata.prev = pv_reg;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_next = res_reg;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cls_reg  <= cls_next;
        page_reg <= page_next;
        off_reg  <= off_next;
        k_reg    <= k_next;
        hd_reg   <= hd_next;
        nx_reg   <= nx_next;
        pv_reg   <= pv_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            free_map_reg  <= '1;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                head_reg[i] <= NIL_PAGE;
            end
        end else begin
            state_reg     <= state_next;
            free_map_reg  <= free_map_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

### hw/rtl/soa_checker.sv
// Port-level checks for the slab object allocator, bound to the top level.
// Depends on soa_pkg and slab_object_allocator.
`default_nettype none
module soa_assertions
    import soa_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    m_valid,
    input logic    m_ready,
    input result_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.object_address == '0)
        else $error("address on failed request");

    a_release_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.page_released |-> m_data.status == ST_OK
            && m_data.object_address == '0)
        else $error("page release on failed or allocate request");

    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.size_class <= MAX_CLASS
            && (m_data.status != ST_TOO_LARGE || m_data.size_class == '0))
        else $error("bad size class");

endmodule

bind slab_object_allocator soa_assertions u_soa_assertions (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

### sim/soa_checker.sv
// Checker for the slab object allocator: watches both channels, predicts each result.
// Depends on soa_pkg; instantiated by testbench beside the block.
`timescale 1ns / 1ps
module soa_checker
    import soa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  request_t s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  result_t  m_data,
    output int       fail_count,
    output int       pending_results,
    output int       results_seen
);

    localparam int PAGE_BYTES = 4096;
    localparam int TOTAL_WORDS = NUM_PAGES * PAGE_BYTES / 8;

    bit        pool_free [NUM_PAGES];
    bit [3:0]  owner_cls [NUM_PAGES];
    bit [9:0]  free_cnt  [NUM_PAGES];
    bit [9:0]  free_top  [NUM_PAGES];
    bit [6:0]  nxt       [NUM_PAGES];
    bit [6:0]  prv       [NUM_PAGES];
    bit [6:0]  class_head[NUM_CLASSES];
    bit [9:0]  obj_next  [TOTAL_WORDS];
    result_t   expected_results[$];

    function automatic int link_word(int page, int k, int osz);
        return (page * PAGE_BYTES + k * osz) / 8;
    endfunction

    function automatic void list_push(int c, int p);
        prv[p] = NIL_PAGE;
        nxt[p] = class_head[c];
        if (class_head[c] < NUM_PAGES) prv[class_head[c]] = 7'(p);
        class_head[c] = 7'(p);
    endfunction

    function automatic void list_drop(int c, int p);
        bit [6:0] n, v;
        n = nxt[p];
        v = prv[p];
        if (v < NUM_PAGES) nxt[v] = n;
        else class_head[c] = n;
        if (n < NUM_PAGES) prv[n] = v;
        nxt[p] = NIL_PAGE;
        prv[p] = NIL_PAGE;
    endfunction

    function automatic result_t predict_allocation(request_t rq);
        result_t r;
        int size, c, osz, per, p, q, k;
        int fa, page;
        r = '0;
        if (rq.opcode == OP_ALLOC) begin
            size = rq.request_size;
            if (rq.request_align > size) size = rq.request_align;
            if (size > MAX_OBJ_BYTES) begin
                r.status = ST_TOO_LARGE;
            end else begin
                c = 0;
                while (c < NUM_CLASSES - 1 && (8 << c) < size) c++;
                r.size_class = 4'(c);
                osz = 8 << c;
                per = PAGE_BYTES / osz;
                p = class_head[c];
                if (p >= NUM_PAGES) begin
                    for (q = 0; q < NUM_PAGES; q++) if (pool_free[q]) break;
                    if (q >= NUM_PAGES) begin
                        r.status = ST_NO_PAGE;
                    end else begin
                        obj_next[link_word(q, 0, osz)] = '0;
                        for (k = 1; k < per; k++) obj_next[link_word(q, k, osz)] = 10'(k - 1);
                        pool_free[q] = 1'b0;
                        owner_cls[q] = 4'(c);
                        free_cnt[q] = 10'(per - 1);
                        free_top[q] = 10'(per - 2);
                        list_push(c, q);
                        r.object_address = 18'(q * PAGE_BYTES + (per - 1) * osz);
                    end
                end else begin
                    k = free_top[p] % per;
                    free_cnt[p]--;
                    free_top[p] = obj_next[link_word(p, k, osz)];
                    if (free_cnt[p] == 0) list_drop(c, p);
                    r.object_address = 18'(p * PAGE_BYTES + k * osz);
                end
            end
        end else begin
            fa = rq.free_address;
            page = fa / PAGE_BYTES;
            if (page >= NUM_PAGES || pool_free[page]) begin
                r.status = ST_UNOWNED;
            end else begin
                c = owner_cls[page];
                if (c >= NUM_CLASSES) c = NUM_CLASSES - 1;
                osz = 8 << c;
                per = PAGE_BYTES / osz;
                k = (fa % PAGE_BYTES) / osz;
                r.size_class = 4'(c);
                obj_next[link_word(page, k, osz)] = free_top[page];
                free_top[page] = 10'(k);
                free_cnt[page]++;
                if (free_cnt[page] == 1) list_push(c, page);
                if (free_cnt[page] >= per) begin
                    list_drop(c, page);
                    pool_free[page] = 1'b1;
                    r.page_released = 1'b1;
                end
            end
        end
        return r;
    endfunction

    assign pending_results = expected_results.size();

    initial begin
        fail_count = 0;
        results_seen = 0;
        foreach (pool_free[i]) begin
            pool_free[i] = 1'b1;
            nxt[i] = NIL_PAGE;
            prv[i] = NIL_PAGE;
        end
        foreach (class_head[i]) class_head[i] = NIL_PAGE;
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) expected_results.push_back(predict_allocation(s_data));
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %p", m_data);
                end else begin
                    want = expected_results.pop_front();
                    if (want !== m_data) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p, got %p", want, m_data);
                    end
                end
            end
        end
    end

endmodule

### sim/testbench.sv
// Stimulus and verdict for the slab object allocator testbench.
// Depends on soa_pkg, soa_checker and the slab_object_allocator RTL.
`timescale 1ns / 1ps
module testbench;
    import soa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic     aclk = 0;
    logic     aresetn = 0;
    logic     s_valid = 0;
    logic     s_ready;
    request_t s_data = '0;
    logic     m_valid;
    logic     m_ready = 0;
    result_t  m_data;
    int       fail_count, pending_results, results_seen;
    int       idle_cycles = 0;
    bit       hold_sink = 0;
    int       sent = 0;
    logic [17:0] live_objects[$];

    always #5 aclk = ~aclk;

    slab_object_allocator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    soa_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_results(pending_results),
        .results_seen(results_seen)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // track allocated addresses so frees usually hit live objects
    always @(posedge aclk) begin
        if (m_valid && m_ready && m_data.status == ST_OK && m_data.object_address != 0
            && m_data.page_released == 0 && live_objects.size() < 4000)
            live_objects.push_back(m_data.object_address);
    end

    always @(posedge aclk) begin
        if (!aresetn || !(s_valid && s_ready) && !(m_valid && m_ready)) idle_cycles <= idle_cycles + 1;
        else idle_cycles <= 0;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : sink
        int g;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_ready <= 0;
                repeat (300) @(posedge aclk);
                hold_sink = 0;
            end
            g = gap_len();
            if ($urandom_range(0, 3) == 0 && g > 0) begin
                m_ready <= 0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
        end
    end

    task automatic send_request(request_t rq);
        s_valid <= 1;
        s_data  <= rq;
        @(posedge aclk iff s_ready);
        sent++;
    endtask

    task automatic idle_sender(int n);
        s_valid <= 0;
        repeat (n) @(posedge aclk);
    endtask

    function automatic request_t make_alloc(int sz, int al);
        request_t rq;
        rq = '0;
        rq.opcode = OP_ALLOC;
        rq.request_size = 16'(sz);
        rq.request_align = 16'(al);
        rq.free_address = 18'($urandom());
        return rq;
    endfunction

    function automatic request_t make_free(logic [17:0] a);
        request_t rq;
        rq.opcode = OP_FREE;
        rq.request_size = 16'($urandom());
        rq.request_align = 16'($urandom());
        rq.free_address = a;
        return rq;
    endfunction

    function automatic int rand_size();
        int c;
        c = $urandom_range(0, 8);
        return $urandom_range((c == 0) ? 0 : (4 << c) + 1, 8 << c);
    endfunction

    task automatic random_request(bit gaps);
        int r, idx;
        logic [17:0] a;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            send_request(make_alloc(rand_size(), $urandom_range(0, 1) ? 0 : rand_size()));
        end else if (r < 85 && live_objects.size() > 0) begin
            idx = $urandom_range(0, live_objects.size() - 1);
            a = live_objects[idx];
            live_objects.delete(idx);
            a = a + 18'($urandom_range(0, 7));
            send_request(make_free(a));
        end else if (r < 92) begin
            send_request(make_alloc(int'($urandom()), int'($urandom())));
        end else begin
            send_request(make_free(18'($urandom())));
        end
        if (gaps) begin
            r = gap_len();
            if (r > 0 && $urandom_range(0, 2) == 0) idle_sender(r);
        end
    endtask

    initial begin
        int i;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // extremes and special cases
        send_request(make_alloc(0, 0));
        send_request(make_alloc(16'hFFFF, 0));
        send_request(make_alloc(0, 16'hFFFF));
        send_request(make_alloc(2048, 0));
        send_request(make_alloc(2049, 0));
        send_request(make_alloc(1, 2048));
        send_request(make_alloc(9, 3));
        send_request(make_free(18'h3FFFF));
        send_request(make_free(18'h0));
        send_request(make_free(18'd4095));
        send_request(make_free(18'd4095));
        send_request(make_free(18'h2AAAA));
        send_request(make_free(18'h15555));
        for (i = 0; i < 9; i++) send_request(make_alloc(8 << i, 8 << i));
        // exhaust the pool with 2048-byte objects
        for (i = 0; i < 130; i++) send_request(make_alloc(2048, 0));
        idle_sender(1);
        wait (pending_results == 0);
        // receiver holds off while sender keeps offering
        hold_sink = 1;
        for (i = 0; i < 40; i++) random_request(0);
        for (i = 0; i < 610; i++) random_request(1);
        s_valid <= 0;
        wait (pending_results == 0);
        repeat (600) @(posedge aclk);
        $display("Sent %0d requests, checked %0d results across all classes,", sent, results_seen);
        $display("including pool exhaustion, oversize, unowned and double frees.");
        if (fail_count == 0 && pending_results == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
